### rtl/ecui_pkg.sv
package ecui_pkg;

	// input selector codes
	localparam logic [1:0] OP_UPDATE = 2'd0;
	localparam logic [1:0] OP_INDEX  = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// configuration register indexes
	localparam logic [1:0] REG_CPR       = 2'd0;
	localparam logic [1:0] REG_JUMP_RATE = 2'd1;
	localparam logic [1:0] REG_INDEX_EN  = 2'd2;

	// register reset values
	localparam logic [16:0] CPR_RESET       = 17'd4096;
	localparam logic [31:0] JUMP_RATE_RESET = 32'd65536;
	localparam logic [16:0] CPR_MAX         = 17'd65536;

	// word handed from the front to the back through the queue
	typedef struct packed {
		logic [63:0] position;
		logic        index_seen;
		logic        jump_flag;
		logic [31:0] jump_total;
		logic [31:0] wrap_total;
		logic [31:0] index_edges;
	} front_word_t;

	// finished result word
	typedef struct packed {
		logic [31:0] index_edges;
		logic [31:0] wrap_total;
		logic [31:0] jump_total;
		logic        jump_flag;
		logic        index_seen;
		logic [15:0] shaft_fraction;
		logic [15:0] shaft_count;
		logic [31:0] turns;
		logic [63:0] position;
	} result_word_t;

endpackage

### rtl/ecui_front.sv
module ecui_front import ecui_pkg::*; #(
	parameter int COUNTER_LIMIT = 16384
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        op,
	input  logic [15:0]       hw_count,
	input  logic [31:0]       dt_us,
	input  logic [31:0]       jump_rate_limit,
	input  logic              index_enable,
	output logic              push,
	input  logic              full,
	output front_word_t       push_word
);

	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_POS  = 2'd1;
	localparam logic [1:0] F_CMP  = 2'd2;
	localparam logic [1:0] F_PUSH = 2'd3;

	localparam logic signed [17:0] LIM  = 18'(COUNTER_LIMIT);
	localparam logic signed [17:0] HALF = 18'(COUNTER_LIMIT / 2);

	logic [1:0]  state_q;
	logic [1:0]  op_q;
	logic [31:0] elapsed_q;
	logic [15:0] last_hw_q;
	logic [63:0] acc_q;
	logic [63:0] origin_q;
	logic        origin_valid_q;
	logic [31:0] edge_cnt_q;
	logic [31:0] wrap_cnt_q;
	logic [31:0] jump_cnt_q;
	logic [63:0] last_upd_q;
	logic [63:0] pos_q;
	logic [63:0] prod_q;
	logic        flag_q;

	logic signed [17:0] d_raw;
	logic signed [17:0] d_fold;
	logic               wrapped;
	logic [63:0]        acc_next;
	logic [63:0]        dc;
	logic [63:0]        mag;
	logic [47:0]        allowed;
	logic               jump;

	// fold the counter step
	always_comb begin
		d_raw = $signed({{2{hw_count[15]}}, hw_count}) - $signed({{2{last_hw_q[15]}}, last_hw_q});
		wrapped = 1'b0;
		d_fold = d_raw;
		if (d_raw < -HALF) begin
			d_fold = d_raw + LIM;
			wrapped = 1'b1;
		end else if (d_raw > HALF) begin
			d_fold = d_raw - LIM;
			wrapped = 1'b1;
		end
		acc_next = acc_q + {{46{d_fold[17]}}, d_fold};
	end

	// jump test on the registered product
	always_comb begin
		dc = pos_q - last_upd_q;
		mag = dc[63] ? (64'd0 - dc) : dc;
		allowed = prod_q[63:16];
		jump = (elapsed_q != 32'd0) && (mag > {16'd0, allowed});
	end

	assign in_ready = (state_q == F_IDLE);
	assign push = (state_q == F_PUSH) && !full;

	always_comb begin
		push_word.position    = pos_q;
		push_word.index_seen  = origin_valid_q;
		push_word.jump_flag   = flag_q;
		push_word.jump_total  = jump_cnt_q;
		push_word.wrap_total  = wrap_cnt_q;
		push_word.index_edges = edge_cnt_q;
	end

	// sequencer and state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			last_hw_q <= '0;
			acc_q <= '0;
			origin_q <= '0;
			origin_valid_q <= 1'b0;
			edge_cnt_q <= '0;
			wrap_cnt_q <= '0;
			jump_cnt_q <= '0;
			last_upd_q <= '0;
			flag_q <= 1'b0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (in_valid) begin
						op_q <= op;
						elapsed_q <= dt_us;
						if (op == OP_UPDATE || op == OP_INDEX) begin
							last_hw_q <= hw_count;
							acc_q <= acc_next;
							if (wrapped)
								wrap_cnt_q <= wrap_cnt_q + 32'd1;
						end
						if (op == OP_INDEX && index_enable) begin
							edge_cnt_q <= edge_cnt_q + 32'd1;
							if (!origin_valid_q) begin
								origin_q <= acc_next;
								origin_valid_q <= 1'b1;
							end
						end
						if (op == OP_CLEAR) begin
							origin_q <= '0;
							origin_valid_q <= 1'b0;
						end
						state_q <= F_POS;
					end
				end
				F_POS: begin
					pos_q <= origin_valid_q ? (acc_q - origin_q) : acc_q;
					prod_q <= 64'(jump_rate_limit) * 64'(elapsed_q);
					state_q <= F_CMP;
				end
				F_CMP: begin
					flag_q <= (op_q == OP_UPDATE) && jump;
					if (op_q == OP_UPDATE) begin
						if (jump)
							jump_cnt_q <= jump_cnt_q + 32'd1;
						last_upd_q <= pos_q;
					end
					state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (!full)
						state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule

### rtl/ecui_fifo.sv
module ecui_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_q;
	logic             rd_q;
	logic [1:0]       cnt_q;

	assign full = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign pop_data = mem_q[rd_q];

	// two-entry queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= !wr_q;
			if (pop)
				rd_q <= !rd_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("pop from empty queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != 2'd3) && ((wr_q == rd_q) == (cnt_q != 2'd1)))
		else $error("queue pointers and count disagree");

endmodule

### rtl/ecui_back.sv
module ecui_back import ecui_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [16:0]   cpr,
	input  logic          empty,
	output logic          pop,
	input  front_word_t   pop_word,
	output logic          out_valid,
	input  logic          out_ready,
	output result_word_t  out_word
);

	localparam logic [2:0] B_IDLE = 3'd0;
	localparam logic [2:0] B_DIV  = 3'd1;
	localparam logic [2:0] B_FIX  = 3'd2;
	localparam logic [2:0] B_FRAC = 3'd3;
	localparam logic [2:0] B_DONE = 3'd4;

	logic [2:0]   state_q;
	front_word_t  item_q;
	logic         neg_q;
	logic [63:0]  dq_q;
	logic [16:0]  r_q;
	logic [5:0]   cnt_q;
	logic [31:0]  turns_q;
	logic [15:0]  shaft_q;
	logic [15:0]  frac_q;

	logic [17:0]  trial;
	logic [17:0]  diff;
	logic         take;
	logic [63:0]  q_fix;
	logic [16:0]  r_fix;

	// one restoring step, shared by both divides
	always_comb begin
		trial = (state_q == B_DIV) ? {r_q, dq_q[63]} : {r_q, 1'b0};
		diff = trial - {1'b0, cpr};
		take = (trial >= {1'b0, cpr});
	end

	// floor correction of the truncating quotient
	always_comb begin
		q_fix = dq_q;
		r_fix = r_q;
		if (neg_q) begin
			if (r_q != 17'd0) begin
				q_fix = ~dq_q;
				r_fix = cpr - r_q;
			end else begin
				q_fix = 64'd0 - dq_q;
			end
		end
	end

	assign pop = (state_q == B_IDLE) && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			out_valid <= 1'b0;
		end else begin
			// result valid: set on load, cleared on handoff
			if (state_q == B_DONE && (!out_valid || out_ready))
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
			unique case (state_q)
				B_IDLE: begin
					if (!empty) begin
						item_q <= pop_word;
						neg_q <= pop_word.position[63];
						dq_q <= pop_word.position[63] ? (64'd0 - pop_word.position)
							: pop_word.position;
						r_q <= '0;
						cnt_q <= 6'd63;
						state_q <= B_DIV;
					end
				end
				B_DIV: begin
					dq_q <= {dq_q[62:0], take};
					r_q <= take ? diff[16:0] : trial[16:0];
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd0)
						state_q <= B_FIX;
				end
				B_FIX: begin
					turns_q <= q_fix[31:0];
					shaft_q <= r_fix[15:0];
					r_q <= r_fix;
					cnt_q <= 6'd15;
					state_q <= B_FRAC;
				end
				B_FRAC: begin
					frac_q <= {frac_q[14:0], take};
					r_q <= take ? diff[16:0] : trial[16:0];
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd0)
						state_q <= B_DONE;
				end
				B_DONE: begin
					if (!out_valid || out_ready)
						state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (state_q == B_DONE && (!out_valid || out_ready)) begin
			out_word.position <= item_q.position;
			out_word.turns <= turns_q;
			out_word.shaft_count <= shaft_q;
			out_word.shaft_fraction <= frac_q;
			out_word.index_seen <= item_q.index_seen;
			out_word.jump_flag <= item_q.jump_flag;
			out_word.jump_total <= item_q.jump_total;
			out_word.wrap_total <= item_q.wrap_total;
			out_word.index_edges <= item_q.index_edges;
		end
	end

endmodule

### rtl/encoder_count_unfold_index.sv
// channel   | direction | tvalid/tready      | payload
// s_*       | in        | s_tvalid/s_tready  | tuser op, tdata hw_count, dt_us
// m_*       | out       | m_tvalid/m_tready  | tdata result word
// cfg_*     | in        | cfg_wen            | cfg_idx, cfg_wdata
//
// A result is produced by the back end's serial divider: 64 restoring steps for
// turns and 16 for the fraction, one bit per cycle; the back end takes a new word
// only after the last result is loaded into its output register.
// The front passes each word through its IDLE, POS, CMP and PUSH states and runs ahead by up to two queued words.
// arst_n clears the accumulated position state and loads register defaults.
// A stalled m_tready holds the result; the back and front stall behind it.
module encoder_count_unfold_index import ecui_pkg::*; #(
	parameter int COUNTER_LIMIT = 16384
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [1:0]   s_tuser,   // op[1:0]
	input  logic [47:0]  s_tdata,   // hw_count[15:0], dt_us[47:16]
	output logic         m_tvalid,
	input  logic         m_tready,
	// position[63:0], turns[95:64], shaft_count[111:96], shaft_fraction[127:112],
	// index_seen[128], jump_flag[129], jump_total[161:130], wrap_total[193:162],
	// index_edges[225:194], zero[231:226]
	output logic [231:0] m_tdata,
	input  logic         cfg_wen,
	input  logic [1:0]   cfg_idx,
	input  logic [31:0]  cfg_wdata
);

	logic [16:0]  cpr_q;
	logic [31:0]  jump_rate_q;
	logic         index_en_q;
	logic [16:0]  cpr_eff;

	logic         push;
	logic         full;
	logic         pop;
	logic         empty;
	front_word_t  push_word;
	front_word_t  pop_word;
	result_word_t out_word;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpr_q <= CPR_RESET;
			jump_rate_q <= JUMP_RATE_RESET;
			index_en_q <= 1'b0;
		end else if (cfg_wen) begin
			unique case (cfg_idx)
				REG_CPR:       cpr_q <= cfg_wdata[16:0];
				REG_JUMP_RATE: jump_rate_q <= cfg_wdata;
				REG_INDEX_EN:  index_en_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// clamp counts per rev to 1..65536
	assign cpr_eff = (cpr_q == 17'd0) ? 17'd1 : ((cpr_q > CPR_MAX) ? CPR_MAX : cpr_q);

	ecui_front #(.COUNTER_LIMIT(COUNTER_LIMIT)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready),
		.op(s_tuser), .hw_count(s_tdata[15:0]), .dt_us(s_tdata[47:16]),
		.jump_rate_limit(jump_rate_q), .index_enable(index_en_q),
		.push(push), .full(full), .push_word(push_word)
	);

	ecui_fifo #(.WIDTH($bits(front_word_t))) u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_data(push_word), .full(full),
		.pop(pop), .pop_data(pop_word), .empty(empty)
	);

	ecui_back u_back (
		.clk(clk), .arst_n(arst_n), .cpr(cpr_eff),
		.empty(empty), .pop(pop), .pop_word(pop_word),
		.out_valid(m_tvalid), .out_ready(m_tready), .out_word(out_word)
	);

	assign m_tdata = {6'd0, out_word};

endmodule

### sim/tb_encoder_count_unfold_index.sv
module tb_encoder_count_unfold_index;
	import ecui_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT      = 16384;
	localparam int DRAIN_WAIT = 120;
	localparam int STALL_MAX  = 20000;
	localparam int HOLD_LEN   = 600;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [1:0]   s_tuser;   // op[1:0]
	logic [47:0]  s_tdata;   // hw_count[15:0], dt_us[47:16]
	logic         m_tvalid;
	logic         m_tready;
	// position, turns, shaft_count, shaft_fraction, index_seen, jump_flag,
	// jump_total, wrap_total, index_edges, zero pad
	logic [231:0] m_tdata;
	logic         cfg_wen;
	logic [1:0]   cfg_idx;
	logic [31:0]  cfg_wdata;

	encoder_count_unfold_index #(.COUNTER_LIMIT(LIMIT)) DUT (.*);

	// predictor copy of configuration and encoder state
	logic [16:0]  cpr_reg;
	logic [31:0]  rate_reg;
	logic         idx_en_reg;
	logic [15:0]  prev_hw;
	logic [63:0]  accum;
	logic [63:0]  origin;
	logic         origin_ok;
	logic [31:0]  edge_cnt;
	logic [31:0]  wrap_cnt;
	logic [31:0]  jump_cnt;
	logic [63:0]  last_upd_pos;

	result_word_t pending_results[$];
	int           mismatches;
	int           words_in;
	int           words_out;
	int           jumps_seen;
	int           tx_idle_pct;
	int           rx_stall_pct;
	bit           hold_req;
	int           quiet_cycles;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// unwrap one counter sample into the accumulator
	function automatic void fold_count(input logic [15:0] hw);
		int d;
		d = int'($signed(hw)) - int'($signed(prev_hw));
		if (d < -(LIMIT / 2)) begin
			d += LIMIT;
			wrap_cnt++;
		end else if (d > LIMIT / 2) begin
			d -= LIMIT;
			wrap_cnt++;
		end
		prev_hw = hw;
		accum = accum + 64'(longint'(d));
	endfunction

	function automatic logic [63:0] cur_pos();
		return origin_ok ? accum - origin : accum;
	endfunction

	// expected result word for one accepted input word
	function automatic result_word_t predict_position(input logic [1:0] op,
			input logic [15:0] hw, input logic [31:0] el);
		result_word_t r;
		logic [63:0]  pos, dc, mag, allowed;
		longint       spos, cpr, rot, rem;
		logic         flag;
		flag = 1'b0;
		case (op)
			OP_UPDATE: begin
				fold_count(hw);
				pos = cur_pos();
				dc = pos - last_upd_pos;
				mag = dc[63] ? -dc : dc;
				allowed = (64'(rate_reg) * 64'(el)) >> 16;
				if (el != 0 && mag > allowed) begin
					flag = 1'b1;
					jump_cnt++;
				end
				last_upd_pos = pos;
			end
			OP_INDEX: begin
				fold_count(hw);
				if (idx_en_reg) begin
					edge_cnt++;
					if (!origin_ok) begin
						origin = accum;
						origin_ok = 1'b1;
					end
				end
			end
			OP_CLEAR: begin
				origin_ok = 1'b0;
				origin = '0;
			end
			default: ;
		endcase
		pos = cur_pos();
		spos = longint'(pos);
		cpr = longint'(cpr_reg);
		if (cpr < 1) cpr = 1;
		if (cpr > 65536) cpr = 65536;
		rot = spos / cpr;
		rem = spos % cpr;
		if (rem < 0) begin
			rem += cpr;
			rot -= 1;
		end
		r.position       = pos;
		r.turns          = rot[31:0];
		r.shaft_count    = rem[15:0];
		r.shaft_fraction = 16'((rem << 16) / cpr);
		r.index_seen     = origin_ok;
		r.jump_flag      = flag;
		r.jump_total     = jump_cnt;
		r.wrap_total     = wrap_cnt;
		r.index_edges    = edge_cnt;
		return r;
	endfunction

	// send one word, sometimes after a random gap; tvalid stays high afterwards
	task automatic send_word(input logic [1:0] op, input logic [15:0] hw,
			input logic [31:0] el);
		result_word_t exp_word;
		if ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {el, hw};
		do @(posedge clk); while (!s_tready);
		exp_word = predict_position(op, hw, el);
		pending_results.push_back(exp_word);
		words_in++;
	endtask

	// stop sending and wait until every result is back and the block is quiet
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		drain();
		cfg_wen   <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wen <= 1'b0;
		case (idx)
			REG_CPR:       cpr_reg = val[16:0];
			REG_JUMP_RATE: rate_reg = val;
			REG_INDEX_EN:  idx_en_reg = val[0];
			default: ;
		endcase
	endtask

	// encoder-like sample: mostly small steps, sometimes wraps and noise
	function automatic logic [15:0] next_count();
		int v;
		int k;
		k = $urandom_range(0, 99);
		if (k < 70)
			v = int'($signed(prev_hw)) + $urandom_range(0, 400) - 200;
		else if (k < 85)
			v = int'($signed(prev_hw)) + $urandom_range(0, 16000) - 8000;
		else
			v = $urandom_range(0, 2 * LIMIT) - LIMIT;
		if (v > LIMIT) v -= LIMIT;
		if (v < -LIMIT) v += LIMIT;
		return 16'(v);
	endfunction

	function automatic logic [31:0] rand_elapsed();
		case ($urandom_range(0, 3))
			0: return 32'($urandom_range(0, 3));
			1: return 32'($urandom_range(1, 500));
			2: return $urandom();
			default: return 32'hFFFF_FFFF;
		endcase
	endfunction

	function automatic logic [1:0] rand_op();
		int k;
		k = $urandom_range(0, 99);
		if (k < 75) return OP_UPDATE;
		if (k < 90) return OP_INDEX;
		if (k < 98) return OP_CLEAR;
		return OP_UNUSED;
	endfunction

	task automatic test_defaults();
		send_word(OP_UPDATE, 16'sd0, 32'd0);
		send_word(OP_UPDATE, 16'sd8192, 32'd1);
		send_word(OP_UPDATE, 16'sd16384, 32'hFFFF_FFFF);
		send_word(OP_UPDATE, -16'sd16384, 32'd10);
		send_word(OP_UPDATE, 16'sd100, 32'd0);
		// index edge while disabled folds but does not latch
		send_word(OP_INDEX, 16'sd200, 32'd5);
		send_word(OP_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);
		send_word(OP_CLEAR, 16'h8000, 32'h8000_0000);
		send_word(OP_UPDATE, -16'sd9000, 32'd3);
	endtask

	task automatic test_index_origin();
		write_reg(REG_INDEX_EN, 32'd1);
		send_word(OP_UPDATE, 16'sd1000, 32'd2);
		send_word(OP_INDEX, 16'sd1500, 32'd0);
		send_word(OP_INDEX, 16'sd2500, 32'd0);   // later edge keeps origin
		send_word(OP_UPDATE, 16'sd500, 32'd100);  // negative position, floor
		send_word(OP_CLEAR, 16'sd0, 32'd0);
		send_word(OP_INDEX, 16'sd0, 32'd0);
	endtask

	task automatic test_config_extremes();
		write_reg(REG_CPR, 32'd1);
		write_reg(REG_JUMP_RATE, 32'd0);
		send_word(OP_UPDATE, 16'sd7, 32'd1);
		send_word(OP_UPDATE, -16'sd7, 32'd0);
		write_reg(REG_CPR, 32'd0);                // out of range, taken as 1
		send_word(OP_UPDATE, 16'sd3, 32'd4);
		write_reg(REG_CPR, 32'h0001_FFFF);        // clamps to 65536
		write_reg(REG_JUMP_RATE, 32'hFFFF_FFFF);
		send_word(OP_UPDATE, -16'sd3000, 32'hFFFF_FFFF);
		write_reg(REG_CPR, 32'd65536);
		send_word(OP_UPDATE, 16'sd12000, 32'd1);
		write_reg(REG_CPR, 32'd3);
		send_word(OP_UPDATE, -16'sd5, 32'd1);
	endtask

	task automatic test_random(input int n, input int tx_pct, input int rx_pct);
		tx_idle_pct  = tx_pct;
		rx_stall_pct = rx_pct;
		for (int i = 0; i < n; i++)
			send_word(rand_op(), next_count(), rand_elapsed());
	endtask

	// receiver holds off long enough for the input side to back up
	task automatic test_backpressure();
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		hold_req = 1'b1;
		for (int i = 0; i < 12; i++)
			send_word(rand_op(), next_count(), rand_elapsed());
		drain();
	endtask

	// receiver: random stalls, with one long hold-off on request
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_LEN) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
			end
		end
	end

	// result check against the oldest expectation
	always @(posedge clk) begin
		result_word_t got;
		result_word_t exp_word;
		if (arst_n && m_tvalid && m_tready) begin
			got = result_word_t'(m_tdata[225:0]);
			words_out++;
			if (got.jump_flag) jumps_seen++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word %h", m_tdata);
			end else begin
				exp_word = pending_results.pop_front();
				if (got.position !== exp_word.position ||
						got.turns !== exp_word.turns ||
						got.shaft_count !== exp_word.shaft_count ||
						got.shaft_fraction !== exp_word.shaft_fraction ||
						got.index_seen !== exp_word.index_seen ||
						got.jump_flag !== exp_word.jump_flag ||
						got.jump_total !== exp_word.jump_total ||
						got.wrap_total !== exp_word.wrap_total ||
						got.index_edges !== exp_word.index_edges) begin
					mismatches++;
					if (mismatches <= 10)
						$display("word %0d mismatch: expected %p, got %p",
							words_out, exp_word, got);
				end
			end
		end
	end

	// watchdog on cycles with no word moving either way
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_MAX) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		s_tvalid <= 1'b0;
		s_tuser <= '0;
		s_tdata <= '0;
		cfg_wen <= 1'b0;
		cfg_idx <= '0;
		cfg_wdata <= '0;
		quiet_cycles = 0;
		hold_req = 1'b0;
		mismatches = 0;
		words_in = 0;
		words_out = 0;
		jumps_seen = 0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		cpr_reg = CPR_RESET;
		rate_reg = JUMP_RATE_RESET;
		idx_en_reg = 1'b0;
		prev_hw = '0;
		accum = '0;
		origin = '0;
		origin_ok = 1'b0;
		edge_cnt = '0;
		wrap_cnt = '0;
		jump_cnt = '0;
		last_upd_pos = '0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_defaults();
		test_index_origin();
		test_config_extremes();
		write_reg(REG_CPR, 32'd4096);
		write_reg(REG_JUMP_RATE, 32'd65536);
		test_random(480, 20, 59);
		write_reg(REG_CPR, 32'd1000);
		write_reg(REG_JUMP_RATE, 32'd2000);
		write_reg(REG_INDEX_EN, 32'd0);
		test_random(480, 59, 20);
		write_reg(REG_CPR, 32'd65536);
		write_reg(REG_JUMP_RATE, 32'd300000);
		write_reg(REG_INDEX_EN, 32'd1);
		test_random(460, 0, 0);
		test_backpressure();

		drain();
		$display("Covered %0d words in, %0d results out, %0d jump flags,", words_in,
			words_out, jumps_seen);
		$display("all ops, index origin handling, cpr/rate extremes and a long stall.");
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

### files.f
rtl/ecui_pkg.sv
rtl/ecui_front.sv
rtl/ecui_fifo.sv
rtl/ecui_back.sv
rtl/encoder_count_unfold_index.sv
sim/tb_encoder_count_unfold_index.sv
